// ----- rtl/msrb_pkg.sv -----
// ----------------------------------------------------------------------------
// msrb_pkg
// Shared constants, field layout and command/result types of the multichannel
// sample ring buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package msrb_pkg;

    localparam int CHANNELS   = 8;
    localparam int CH_W       = $clog2(CHANNELS);
    localparam int RING_DEPTH = 256;
    localparam int SLOT_W     = $clog2(RING_DEPTH);
    localparam int CAP_W      = SLOT_W + 1;
    localparam int ADDR_W     = CH_W + SLOT_W;
    localparam int READ_MAX   = 64;

    localparam int CHAN_W  = 4;
    localparam int USED_W  = 4;
    localparam int SEQ_W   = 64;
    localparam int STAMP_W = 64;
    localparam int VAL_W   = 32;
    localparam int CNT_W   = 7;

    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 1'b1;
    localparam logic [CAP_W-1:0]     CAP_RESET    = CAP_W'(RING_DEPTH);

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // input beat layout
    localparam int S_CHAN_LSB  = 0;
    localparam int S_STAMP_LSB = S_CHAN_LSB + CHAN_W;
    localparam int S_VAL_LSB   = S_STAMP_LSB + STAMP_W;
    localparam int S_LIM_LSB   = S_VAL_LSB + VAL_W;
    localparam int S_CUR_LSB   = S_LIM_LSB + CNT_W;
    localparam int S_USED_W    = S_CUR_LSB + SEQ_W;
    localparam int S_TDATA_W   = ((S_USED_W + 7) / 8) * 8;
    localparam int S_TUSER_W   = 1;

    // result beat layout
    localparam int M_SEQ_LSB   = 0;
    localparam int M_STAMP_LSB = M_SEQ_LSB + SEQ_W;
    localparam int M_VAL_LSB   = M_STAMP_LSB + STAMP_W;
    localparam int M_CNT_LSB   = M_VAL_LSB + VAL_W;
    localparam int M_CUR_LSB   = M_CNT_LSB + CNT_W;
    localparam int M_USED_W    = M_CUR_LSB + SEQ_W;
    localparam int M_TDATA_W   = ((M_USED_W + 7) / 8) * 8;
    localparam int M_TUSER_W   = 2;
    localparam int M_MOVED_BIT   = 0;
    localparam int M_CARRIES_BIT = 1;

    // remainder unit
    localparam int MOD_DIGIT_W = 8;
    localparam int MOD_STEPS   = SEQ_W / MOD_DIGIT_W;
    localparam int MOD_CNT_W   = $clog2(MOD_STEPS);

    // command queue
    localparam int QUEUE_DEPTH = 4;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_EMPTY = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                  kind;
        logic                       wr;
        logic [CH_W-1:0]            chan;
        logic [SLOT_W-1:0]          slot;
        logic [SEQ_W-1:0]           seq;
        logic signed [STAMP_W-1:0]  stamp;
        logic [VAL_W-1:0]           value;
        logic [CNT_W-1:0]           count;
        logic [SEQ_W-1:0]           cursor;
    } cmd_t;

    typedef struct packed {
        logic [SEQ_W-1:0]           seq;
        logic signed [STAMP_W-1:0]  stamp;
        logic [VAL_W-1:0]           value;
        logic [CNT_W-1:0]           count;
        logic [SEQ_W-1:0]           cursor;
        logic                       moved;
        logic                       carries;
        logic                       last;
    } res_t;

endpackage

`default_nettype wire

// ----- rtl/msrb_mod.sv -----
// ----------------------------------------------------------------------------
// msrb_mod
// Iterative remainder of a sequence word by the ring capacity, one byte of
// the dividend per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module msrb_mod (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           start,
    input  wire logic [msrb_pkg::SEQ_W-1:0]     dividend,
    input  wire logic [msrb_pkg::CAP_W-1:0]     divisor,
    output logic                                done,
    output logic [msrb_pkg::SLOT_W-1:0]         rem
);

    logic                               busy_reg;
    logic                               done_reg;
    logic [msrb_pkg::MOD_CNT_W-1:0]     cnt_reg;
    logic [msrb_pkg::SEQ_W-1:0]         dvd_reg;
    logic [msrb_pkg::SLOT_W-1:0]        rem_reg;
    logic [msrb_pkg::SLOT_W-1:0]        rem_next;

    always_comb begin
        logic [msrb_pkg::CAP_W-1:0] t;
        logic [msrb_pkg::SLOT_W-1:0] r;
        r = rem_reg;
        for (int i = 0; i < msrb_pkg::MOD_DIGIT_W; i++) begin
            t = {r, dvd_reg[msrb_pkg::SEQ_W-1-i]};
            if (t >= divisor) begin
                t = t - divisor;
            end
            r = t[msrb_pkg::SLOT_W-1:0];
        end
        rem_next = r;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == msrb_pkg::MOD_CNT_W'(msrb_pkg::MOD_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= dvd_reg << msrb_pkg::MOD_DIGIT_W;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

// ----- rtl/msrb_front.sv -----
// ----------------------------------------------------------------------------
// msrb_front
// Accepts requests, keeps the per-channel sequence counters and write slots,
// resolves reads into a start sequence and count, and queues commands.
// ----------------------------------------------------------------------------
`default_nettype none

module msrb_front (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [msrb_pkg::S_TDATA_W-1:0]     s_tdata,
    input  wire logic [msrb_pkg::S_TUSER_W-1:0]     s_tuser,
    input  wire logic [msrb_pkg::CAP_W-1:0]         cap,
    input  wire logic [msrb_pkg::USED_W-1:0]        used,
    input  wire logic                               cap_write,
    output logic                                    q_valid,
    input  wire logic                               q_ready,
    output msrb_pkg::cmd_t                          q_cmd
);

    typedef enum logic [5:0] {
        F_IDLE     = 6'b000001,
        F_CALC     = 6'b000010,
        F_CLAMP    = 6'b000100,
        F_ISSUE    = 6'b001000,
        F_RC_START = 6'b010000,
        F_RC_WAIT  = 6'b100000
    } front_state_t;

    front_state_t state_reg, state_next;

    logic                               req_reg;
    logic [msrb_pkg::CHAN_W-1:0]        ch_reg;
    logic signed [msrb_pkg::STAMP_W-1:0] stamp_reg;
    logic [msrb_pkg::VAL_W-1:0]         val_reg;
    logic [msrb_pkg::CNT_W-1:0]         lim_reg;
    logic [msrb_pkg::SEQ_W-1:0]         cursor_reg;

    logic [msrb_pkg::SEQ_W-1:0]         nseq_reg  [msrb_pkg::CHANNELS];
    logic [msrb_pkg::SLOT_W-1:0]        wslot_reg [msrb_pkg::CHANNELS];

    logic [msrb_pkg::SEQ_W-1:0]         newest_reg;
    logic [msrb_pkg::SEQ_W-1:0]         oldm1_reg;
    logic [msrb_pkg::SEQ_W-1:0]         cand_reg;
    logic [msrb_pkg::SEQ_W-1:0]         start_reg;
    logic                               empty0_reg;
    logic                               empty_reg;
    logic [msrb_pkg::CAP_W-1:0]         d_reg;

    logic [msrb_pkg::CH_W-1:0]          rc_ch_reg;
    logic                               rc_pend_reg, rc_pend_next;

    logic                               accept;
    logic                               in_rc;
    logic [msrb_pkg::CH_W-1:0]          rd_idx;
    logic [msrb_pkg::SEQ_W-1:0]         nseq_rd;
    logic [msrb_pkg::SLOT_W-1:0]        wslot_rd;
    logic [msrb_pkg::USED_W-1:0]        used_eff;
    logic                               known;
    logic [msrb_pkg::CNT_W-1:0]         lim_in;
    logic [msrb_pkg::CAP_W-1:0]         wslot_inc;
    logic [msrb_pkg::SLOT_W-1:0]        wslot_adv;

    logic [msrb_pkg::SEQ_W-1:0]         newest;
    logic [msrb_pkg::SEQ_W-1:0]         oldm1;
    logic [msrb_pkg::SEQ_W-1:0]         tail;
    logic [msrb_pkg::SEQ_W-1:0]         start;
    logic [msrb_pkg::SEQ_W-1:0]         diff;
    logic [msrb_pkg::CNT_W-1:0]         n;
    logic [msrb_pkg::CAP_W:0]           slot_diff;
    logic [msrb_pkg::CAP_W:0]           slot_fix;

    logic                               mod_start;
    logic                               mod_done;
    logic [msrb_pkg::SLOT_W-1:0]        mod_rem;

    msrb_mod u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mod_start),
        .dividend (nseq_rd - msrb_pkg::SEQ_W'(1)),
        .divisor  (cap),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    assign s_tready  = aresetn && (state_reg == F_IDLE) && !rc_pend_reg && !cap_write;
    assign accept    = s_tvalid && s_tready;
    assign in_rc     = (state_reg == F_RC_START) || (state_reg == F_RC_WAIT);
    assign rd_idx    = in_rc ? rc_ch_reg : ch_reg[msrb_pkg::CH_W-1:0];
    assign nseq_rd   = nseq_reg[rd_idx];
    assign wslot_rd  = wslot_reg[rd_idx];
    assign used_eff  = (used > msrb_pkg::USED_W'(msrb_pkg::CHANNELS)) ?
                       msrb_pkg::USED_W'(msrb_pkg::CHANNELS) : used;
    assign known     = ch_reg < used_eff;
    assign mod_start = (state_reg == F_RC_START);

    assign lim_in = (s_tdata[msrb_pkg::S_LIM_LSB +: msrb_pkg::CNT_W] >
                     msrb_pkg::CNT_W'(msrb_pkg::READ_MAX)) ?
                    msrb_pkg::CNT_W'(msrb_pkg::READ_MAX) :
                    s_tdata[msrb_pkg::S_LIM_LSB +: msrb_pkg::CNT_W];

    assign wslot_inc = {1'b0, wslot_rd} + msrb_pkg::CAP_W'(1);
    assign wslot_adv = (wslot_inc == cap) ? '0 : wslot_inc[msrb_pkg::SLOT_W-1:0];

    // resolve window limits
    assign newest = nseq_rd - msrb_pkg::SEQ_W'(1);
    assign oldm1  = (newest > msrb_pkg::SEQ_W'(cap)) ? newest - msrb_pkg::SEQ_W'(cap) : '0;
    assign tail   = (newest > msrb_pkg::SEQ_W'(lim_reg)) ?
                    newest - msrb_pkg::SEQ_W'(lim_reg) : '0;

    // clamp to the oldest held sample
    assign start = (cand_reg < oldm1_reg) ? oldm1_reg : cand_reg;
    assign diff  = newest_reg - start;

    assign n         = ({2'b00, lim_reg} < d_reg) ? lim_reg : d_reg[msrb_pkg::CNT_W-1:0];
    assign slot_diff = {2'b00, wslot_rd} - {1'b0, d_reg};
    assign slot_fix  = slot_diff[msrb_pkg::CAP_W] ? slot_diff + {1'b0, cap} : slot_diff;

    always_comb begin
        q_valid = 1'b0;
        q_cmd   = '0;
        if ((state_reg == F_CALC) && (req_reg == msrb_pkg::REQ_PUSH)) begin
            q_valid      = 1'b1;
            q_cmd.kind   = msrb_pkg::CMD_PUSH;
            q_cmd.wr     = known;
            q_cmd.chan   = ch_reg[msrb_pkg::CH_W-1:0];
            q_cmd.slot   = wslot_rd;
            q_cmd.seq    = known ? nseq_rd : '0;
            q_cmd.stamp  = stamp_reg;
            q_cmd.value  = val_reg;
        end else if (state_reg == F_ISSUE) begin
            q_valid = 1'b1;
            if (empty_reg) begin
                q_cmd.kind   = msrb_pkg::CMD_EMPTY;
                q_cmd.cursor = cursor_reg;
            end else begin
                q_cmd.kind   = msrb_pkg::CMD_READ;
                q_cmd.chan   = ch_reg[msrb_pkg::CH_W-1:0];
                q_cmd.slot   = slot_fix[msrb_pkg::SLOT_W-1:0];
                q_cmd.seq    = start_reg + msrb_pkg::SEQ_W'(1);
                q_cmd.count  = n;
                q_cmd.cursor = start_reg + msrb_pkg::SEQ_W'(n);
            end
        end
    end

    always_comb begin
        state_next   = state_reg;
        rc_pend_next = rc_pend_reg;
        case (state_reg)
            F_IDLE: begin
                if (rc_pend_reg) begin
                    state_next   = F_RC_START;
                    rc_pend_next = 1'b0;
                end else if (accept) begin
                    state_next = F_CALC;
                end
            end
            F_CALC: begin
                if (req_reg == msrb_pkg::REQ_READ) begin
                    state_next = F_CLAMP;
                end else if (q_ready) begin
                    state_next = F_IDLE;
                end
            end
            F_CLAMP: state_next = F_ISSUE;
            F_ISSUE: begin
                if (q_ready) begin
                    state_next = F_IDLE;
                end
            end
            F_RC_START: state_next = F_RC_WAIT;
            F_RC_WAIT: begin
                if (mod_done) begin
                    state_next = (rc_ch_reg == msrb_pkg::CH_W'(msrb_pkg::CHANNELS - 1)) ?
                                 F_IDLE : F_RC_START;
                end
            end
            default: state_next = F_IDLE;
        endcase
        if (cap_write) begin
            rc_pend_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= F_IDLE;
            rc_pend_reg <= 1'b0;
            rc_ch_reg   <= '0;
            for (int c = 0; c < msrb_pkg::CHANNELS; c++) begin
                nseq_reg[c]  <= msrb_pkg::SEQ_W'(1);
                wslot_reg[c] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            rc_pend_reg <= rc_pend_next;
            if ((state_reg == F_IDLE) && rc_pend_reg) begin
                rc_ch_reg <= '0;
            end
            if ((state_reg == F_CALC) && (req_reg == msrb_pkg::REQ_PUSH) && q_ready && known) begin
                nseq_reg[rd_idx]  <= nseq_rd + msrb_pkg::SEQ_W'(1);
                wslot_reg[rd_idx] <= wslot_adv;
            end
            if ((state_reg == F_RC_WAIT) && mod_done) begin
                wslot_reg[rc_ch_reg] <= mod_rem;
                rc_ch_reg            <= rc_ch_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg    <= s_tuser[0];
            ch_reg     <= s_tdata[msrb_pkg::S_CHAN_LSB +: msrb_pkg::CHAN_W];
            stamp_reg  <= s_tdata[msrb_pkg::S_STAMP_LSB +: msrb_pkg::STAMP_W];
            val_reg    <= s_tdata[msrb_pkg::S_VAL_LSB +: msrb_pkg::VAL_W];
            lim_reg    <= lim_in;
            cursor_reg <= s_tdata[msrb_pkg::S_CUR_LSB +: msrb_pkg::SEQ_W];
        end
        if (state_reg == F_CALC) begin
            newest_reg <= newest;
            oldm1_reg  <= oldm1;
            cand_reg   <= (cursor_reg == '0) ? tail : cursor_reg;
            empty0_reg <= (lim_reg == '0) || !known || (newest == '0);
        end
        if (state_reg == F_CLAMP) begin
            start_reg <= start;
            empty_reg <= empty0_reg || (start >= newest_reg);
            d_reg     <= diff[msrb_pkg::CAP_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/msrb_fifo.sv -----
// ----------------------------------------------------------------------------
// msrb_fifo
// Short command queue between the request front and the sample back end.
// ----------------------------------------------------------------------------
`default_nettype none

module msrb_fifo (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire msrb_pkg::cmd_t     in_cmd,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output msrb_pkg::cmd_t          out_cmd
);

    msrb_pkg::cmd_t                 entry_reg [msrb_pkg::QUEUE_DEPTH];
    logic [msrb_pkg::Q_PTR_W-1:0]   wr_ptr_reg;
    logic [msrb_pkg::Q_PTR_W-1:0]   rd_ptr_reg;
    logic [msrb_pkg::Q_PTR_W:0]     cnt_reg, cnt_next;
    logic                           push;
    logic                           pop;

    assign in_ready  = cnt_reg != (msrb_pkg::Q_PTR_W + 1)'(msrb_pkg::QUEUE_DEPTH);
    assign out_valid = cnt_reg != '0;
    assign out_cmd   = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/msrb_back.sv -----
// ----------------------------------------------------------------------------
// msrb_back
// Carries out queued commands: writes pushed samples into the sample memory,
// streams read samples out of it and holds the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module msrb_back (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           q_valid,
    output logic                                q_ready,
    input  wire msrb_pkg::cmd_t                 q_cmd,
    input  wire logic [msrb_pkg::CAP_W-1:0]     cap,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output msrb_pkg::res_t                      m_res
);

    localparam int ENTRY_W = msrb_pkg::STAMP_W + msrb_pkg::VAL_W;
    localparam int MEM_DEPTH = msrb_pkg::CHANNELS * msrb_pkg::RING_DEPTH;

    typedef enum logic [1:0] {
        B_IDLE = 2'b01,
        B_READ = 2'b10
    } back_state_t;

    back_state_t state_reg, state_next;

    logic [ENTRY_W-1:0]                 mem [MEM_DEPTH];
    logic [ENTRY_W-1:0]                 mem_q_reg;

    logic [msrb_pkg::CH_W-1:0]          chan_reg;
    logic [msrb_pkg::SLOT_W-1:0]        slot_reg;
    logic [msrb_pkg::SEQ_W-1:0]         seq_reg;
    logic [msrb_pkg::CNT_W-1:0]         count_reg;
    logic [msrb_pkg::CNT_W-1:0]         remain_reg;
    logic [msrb_pkg::SEQ_W-1:0]         cursor_reg;
    logic                               pend_reg;
    logic [msrb_pkg::SEQ_W-1:0]         pend_seq_reg;
    logic                               pend_last_reg;
    logic                               out_valid_reg;
    msrb_pkg::res_t                     out_reg, out_next;

    logic                               out_free;
    logic                               pop;
    logic                               issue;
    logic                               load;
    logic                               mem_we;
    logic [msrb_pkg::CAP_W-1:0]         slot_inc;

    assign out_free = !out_valid_reg || m_ready;
    assign q_ready  = (state_reg == B_IDLE) && !pend_reg && out_free;
    assign pop      = q_valid && q_ready;
    assign issue    = (state_reg == B_READ) && !pend_reg && out_free;
    assign mem_we   = pop && (q_cmd.kind == msrb_pkg::CMD_PUSH) && q_cmd.wr;
    assign slot_inc = {1'b0, slot_reg} + msrb_pkg::CAP_W'(1);

    always_comb begin
        state_next = state_reg;
        load       = 1'b0;
        out_next   = '0;
        if (pend_reg) begin
            load             = 1'b1;
            out_next.seq     = pend_seq_reg;
            out_next.stamp   = mem_q_reg[msrb_pkg::STAMP_W-1:0];
            out_next.value   = mem_q_reg[ENTRY_W-1:msrb_pkg::STAMP_W];
            out_next.count   = count_reg;
            out_next.cursor  = cursor_reg;
            out_next.moved   = 1'b1;
            out_next.carries = 1'b1;
            out_next.last    = pend_last_reg;
        end else if (pop) begin
            case (q_cmd.kind)
                msrb_pkg::CMD_PUSH: begin
                    load          = 1'b1;
                    out_next.seq  = q_cmd.seq;
                    out_next.last = 1'b1;
                end
                msrb_pkg::CMD_EMPTY: begin
                    load            = 1'b1;
                    out_next.cursor = q_cmd.cursor;
                    out_next.last   = 1'b1;
                end
                msrb_pkg::CMD_READ: state_next = B_READ;
                default: state_next = B_IDLE;
            endcase
        end
        if (issue && (remain_reg == msrb_pkg::CNT_W'(1))) begin
            state_next = B_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= issue;
            if (load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_reg <= out_next;
        end
        if (pop && (q_cmd.kind == msrb_pkg::CMD_READ)) begin
            chan_reg   <= q_cmd.chan;
            slot_reg   <= q_cmd.slot;
            seq_reg    <= q_cmd.seq;
            count_reg  <= q_cmd.count;
            remain_reg <= q_cmd.count;
            cursor_reg <= q_cmd.cursor;
        end
        if (issue) begin
            pend_seq_reg  <= seq_reg;
            pend_last_reg <= remain_reg == msrb_pkg::CNT_W'(1);
            seq_reg       <= seq_reg + msrb_pkg::SEQ_W'(1);
            slot_reg      <= (slot_inc == cap) ? '0 : slot_inc[msrb_pkg::SLOT_W-1:0];
            remain_reg    <= remain_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[{q_cmd.chan, q_cmd.slot}] <= {q_cmd.value, q_cmd.stamp};
        end
        if (issue) begin
            mem_q_reg <= mem[{chan_reg, slot_reg}];
        end
    end

    assign m_valid = out_valid_reg;
    assign m_res   = out_reg;

endmodule

`default_nettype wire

// ----- rtl/multichannel_sample_ring_buffer.sv -----
// ----------------------------------------------------------------------------
// multichannel_sample_ring_buffer
// Eight channel rings of timestamped samples with sequence numbers, pushed
// and read back through a cursor.
// ----------------------------------------------------------------------------
// A push is taken in F_IDLE and queued from F_CALC, giving one result beat; a
// read resolves its window through F_CALC, F_CLAMP and F_ISSUE, then each
// returned sample is issued and then loaded from the registered read of the
// single sample memory; a sample is not issued until the last one is loaded.
// A short command queue lets requests be taken while earlier reads still
// stream. A write to ring_capacity starts a recompute of every channel's write
// slot by the byte-serial remainder unit, during which no request is taken.
`default_nettype none

module multichannel_sample_ring_buffer (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // channel, stamp_ns, sample_bits, read_limit, cursor_in, zero pad
    input  wire logic [msrb_pkg::S_TDATA_W-1:0]     s_tdata,
    // req_type
    input  wire logic [msrb_pkg::S_TUSER_W-1:0]     s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // seq_number, stamp_out, sample_out, returned_count, cursor_out, zero pad
    output logic [msrb_pkg::M_TDATA_W-1:0]          m_tdata,
    // cursor_moved, carries_sample
    output logic [msrb_pkg::M_TUSER_W-1:0]          m_tuser,
    output logic                                    m_tlast,
    input  wire logic                               cfg_we,
    input  wire logic [msrb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [msrb_pkg::CFG_W-1:0]         cfg_wdata
);

    logic [msrb_pkg::CAP_W-1:0]     cap_reg;
    logic [msrb_pkg::USED_W-1:0]    used_reg;
    logic [msrb_pkg::CAP_W-1:0]     cap_eff;
    logic                           cap_write;

    logic                           fq_valid, fq_ready;
    msrb_pkg::cmd_t                 fq_cmd;
    logic                           bq_valid, bq_ready;
    msrb_pkg::cmd_t                 bq_cmd;
    msrb_pkg::res_t                 res;

    assign cap_write = cfg_we && (cfg_index == msrb_pkg::REG_CAPACITY);

    assign cap_eff = (cap_reg == '0) ? msrb_pkg::CAP_W'(1) :
                     (cap_reg > msrb_pkg::CAP_W'(msrb_pkg::RING_DEPTH)) ?
                     msrb_pkg::CAP_W'(msrb_pkg::RING_DEPTH) : cap_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg  <= msrb_pkg::CAP_RESET;
            used_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                msrb_pkg::REG_CAPACITY: cap_reg  <= cfg_wdata[msrb_pkg::CAP_W-1:0];
                msrb_pkg::REG_CHANNELS: used_reg <= cfg_wdata[msrb_pkg::USED_W-1:0];
                default: ;
            endcase
        end
    end

    msrb_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cap       (cap_eff),
        .used      (used_reg),
        .cap_write (cap_write),
        .q_valid   (fq_valid),
        .q_ready   (fq_ready),
        .q_cmd     (fq_cmd)
    );

    msrb_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_cmd    (fq_cmd),
        .out_valid (bq_valid),
        .out_ready (bq_ready),
        .out_cmd   (bq_cmd)
    );

    msrb_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (bq_valid),
        .q_ready (bq_ready),
        .q_cmd   (bq_cmd),
        .cap     (cap_eff),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_res   (res)
    );

    always_comb begin
        m_tdata = '0;
        m_tdata[msrb_pkg::M_SEQ_LSB   +: msrb_pkg::SEQ_W]   = res.seq;
        m_tdata[msrb_pkg::M_STAMP_LSB +: msrb_pkg::STAMP_W] = res.stamp;
        m_tdata[msrb_pkg::M_VAL_LSB   +: msrb_pkg::VAL_W]   = res.value;
        m_tdata[msrb_pkg::M_CNT_LSB   +: msrb_pkg::CNT_W]   = res.count;
        m_tdata[msrb_pkg::M_CUR_LSB   +: msrb_pkg::SEQ_W]   = res.cursor;
        m_tuser = '0;
        m_tuser[msrb_pkg::M_MOVED_BIT]   = res.moved;
        m_tuser[msrb_pkg::M_CARRIES_BIT] = res.carries;
    end

    assign m_tlast = res.last;

endmodule

`default_nettype wire

// ----- rtl/msrb_checker.sv -----
// ----------------------------------------------------------------------------
// msrb_checker
// Port-level checks on the result stream of the sample ring buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module msrb_checker (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               m_tvalid,
    input  wire logic                               m_tready,
    input  wire logic [msrb_pkg::M_TDATA_W-1:0]     m_tdata,
    input  wire logic [msrb_pkg::M_TUSER_W-1:0]     m_tuser,
    input  wire logic                               m_tlast
);

    logic                               carries;
    logic                               moved;
    logic [msrb_pkg::SEQ_W-1:0]         seq;
    logic [msrb_pkg::STAMP_W-1:0]       stamp;
    logic [msrb_pkg::VAL_W-1:0]         value;
    logic [msrb_pkg::CNT_W-1:0]         count;
    logic [msrb_pkg::SEQ_W-1:0]         cursor;

    assign carries = m_tuser[msrb_pkg::M_CARRIES_BIT];
    assign moved   = m_tuser[msrb_pkg::M_MOVED_BIT];
    assign seq     = m_tdata[msrb_pkg::M_SEQ_LSB   +: msrb_pkg::SEQ_W];
    assign stamp   = m_tdata[msrb_pkg::M_STAMP_LSB +: msrb_pkg::STAMP_W];
    assign value   = m_tdata[msrb_pkg::M_VAL_LSB   +: msrb_pkg::VAL_W];
    assign count   = m_tdata[msrb_pkg::M_CNT_LSB   +: msrb_pkg::CNT_W];
    assign cursor  = m_tdata[msrb_pkg::M_CUR_LSB   +: msrb_pkg::SEQ_W];

    // hold a stalled beat
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
        && $stable(m_tlast))
        else $error("result beat changed while stalled");

    a_moved: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> moved == carries)
        else $error("cursor_moved and carries_sample disagree");

    a_plain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !carries |-> m_tlast && stamp == '0 && value == '0 && count == '0)
        else $error("push or empty result carries sample fields");

    a_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && carries |-> count != '0 && seq != '0)
        else $error("sample beat without count or sequence");

    a_final: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && carries && m_tlast |-> cursor == seq)
        else $error("final sample does not match advanced cursor");

endmodule

bind multichannel_sample_ring_buffer msrb_checker u_msrb_checker (.*);

`default_nettype wire
